### rtl/core/rsb_pkg.sv
// ----------------------------------------------------------------------------
// rsb_pkg
// Shared types and constants for the resample ratio buffer servo.
// ----------------------------------------------------------------------------
package rsb_pkg;

  localparam int BLK_W       = 16;          // block_length register width
  localparam int DIVISOR_W   = BLK_W + 1;   // holds 2*block_length, 10 and 1000
  localparam int BLK_RST     = 441;
  localparam int CAP_RST     = 88200;
  localparam int NOM_DIV_W   = 4;           // divisor width for nominal/10

  localparam int TEN         = 10;
  localparam int THOUSAND    = 1000;
  localparam int SLOW_KEEP   = 999;         // out of band: 999/1000 of ratio kept
  localparam int FAST_KEEP   = 9;           // in band: 9/10 of ratio kept
  localparam int BAND_SCALE  = 100;
  localparam int BAND_LO     = 49;
  localparam int BAND_HI     = 51;

  typedef enum logic [1:0] {
    REG_NOMINAL  = 2'd0,
    REG_CAPACITY = 2'd1,
    REG_BLOCK    = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START1,
    ST_WAIT1,
    ST_CLAMP,
    ST_START2,
    ST_WAIT2,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic capture;   // latch fill level
    logic start1;    // start error divide and nominal/10
    logic clamp;     // form clamped estimate
    logic start2;    // start the smoothing divide
    logic finish;    // update ratio and load output word
  } cmd_t;

  typedef struct packed {
    logic div_busy;
  } status_t;

endpackage

### rtl/core/rsb_fill_if.sv
// ----------------------------------------------------------------------------
// rsb_fill_if
// Input channel: one fill level word per audio block.
// ----------------------------------------------------------------------------
interface rsb_fill_if #(
  parameter int FILL_BITS = 20
);
  logic                 valid;
  logic                 ready;
  logic [FILL_BITS-1:0] fill_level;

  modport source (output valid, output fill_level, input ready);
  modport sink   (input valid, input fill_level, output ready);
endinterface

### rtl/core/rsb_ratio_if.sv
// ----------------------------------------------------------------------------
// rsb_ratio_if
// Output channel: updated ratio with band and clamp flags.
// ----------------------------------------------------------------------------
interface rsb_ratio_if #(
  parameter int RATIO_BITS = 24
);
  logic                  valid;
  logic                  ready;
  logic [RATIO_BITS-1:0] ratio;
  logic                  in_band;
  logic                  clamped;

  modport source (output valid, output ratio, output in_band, output clamped, input ready);
  modport sink   (input valid, input ratio, input in_band, input clamped, output ready);
endinterface

### rtl/core/resample_ratio_buffer_servo.sv
// ----------------------------------------------------------------------------
// resample_ratio_buffer_servo
// Buffer-fill servo that updates a fixed-point resampling ratio per block.
// ----------------------------------------------------------------------------
// Processing: a new fill word is accepted only once the previous one has been
//   finished and its result word loaded; each word makes two passes through the
//   radix-4 restoring divider (fill error divide, then smoothing divide), and the
//   result word waits while the output still holds an unaccepted word.
// Reset: ratio and nominal to 1.0, capacity 88200, block length 441, idle.
module resample_ratio_buffer_servo #(
  parameter int RATIO_FRAC_BITS = 20,
  parameter int FILL_BITS       = 20
) (
  input  logic clk,
  input  logic rst,

  rsb_fill_if.sink    fill,
  rsb_ratio_if.source result,

  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [$clog2(3*(((RATIO_FRAC_BITS+4) > 32) ? 8 : 4))-1:0] paddr,
  input  logic [((RATIO_FRAC_BITS+4) > 32 ? 64 : 32)-1:0]           pwdata,
  output logic [((RATIO_FRAC_BITS+4) > 32 ? 64 : 32)-1:0]           prdata,
  output logic                                    pready
);

  localparam int RB     = RATIO_FRAC_BITS + 4;
  localparam int PW     = (RB > 32) ? 64 : 32;
  localparam int STRIDE = PW / 8;
  localparam int AW     = $clog2(3 * STRIDE);
  localparam int SB     = $clog2(STRIDE);
  localparam logic [RB-1:0]             NOM_RST = RB'(1) << RATIO_FRAC_BITS;
  localparam logic [FILL_BITS-1:0]      CAP_RST = FILL_BITS'(rsb_pkg::CAP_RST);
  localparam logic [rsb_pkg::BLK_W-1:0] BLK_RST = rsb_pkg::BLK_W'(rsb_pkg::BLK_RST);

  logic [RB-1:0]             nominal;
  logic [FILL_BITS-1:0]      capacity;
  logic [rsb_pkg::BLK_W-1:0] blk;

  rsb_pkg::reg_idx_t idx;
  logic              wr;

  assign pready = 1'b1;
  assign idx    = rsb_pkg::reg_idx_t'(paddr[AW-1:SB]);
  assign wr     = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      nominal  <= NOM_RST;
      capacity <= CAP_RST;
      blk      <= BLK_RST;
    end else if (wr) begin
      case (idx)
        rsb_pkg::REG_NOMINAL:  nominal  <= pwdata[RB-1:0];
        rsb_pkg::REG_CAPACITY: capacity <= pwdata[FILL_BITS-1:0];
        rsb_pkg::REG_BLOCK:    blk      <= pwdata[rsb_pkg::BLK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      rsb_pkg::REG_NOMINAL:  prdata = PW'(nominal);
      rsb_pkg::REG_CAPACITY: prdata = PW'(capacity);
      rsb_pkg::REG_BLOCK:    prdata = PW'(blk);
      default:               prdata = '0;
    endcase
  end

  rsb_pkg::cmd_t    cmd;
  rsb_pkg::status_t status;

  rsb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fill.valid),
    .in_ready  (fill.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .cmd       (cmd),
    .status    (status)
  );

  rsb_dp #(
    .RATIO_FRAC_BITS(RATIO_FRAC_BITS),
    .FILL_BITS      (FILL_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .fill_level (fill.fill_level),
    .nominal    (nominal),
    .capacity   (capacity),
    .blk        (blk),
    .nom_load   (wr && (idx == rsb_pkg::REG_NOMINAL)),
    .nom_wdata  (pwdata[RB-1:0]),
    .ratio      (result.ratio),
    .in_band    (result.in_band),
    .clamped    (result.clamped)
  );

endmodule

### rtl/core/rsb_div.sv
// ----------------------------------------------------------------------------
// rsb_div
// Restoring unsigned divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module rsb_div #(
  parameter int DW = 41,
  parameter int VW = 17
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          busy,
  output logic [DW-1:0] quotient,
  output logic [VW-1:0] remainder
);

  localparam int STEPS = (DW + 1) / 2;
  localparam int DWP   = 2 * STEPS;
  localparam int CW    = $clog2(STEPS + 1);

  logic [DWP-1:0] q;
  logic [VW-1:0]  rem;
  logic [VW-1:0]  d;
  logic [CW-1:0]  cnt;

  logic [DWP-1:0] q_next;
  logic [VW-1:0]  rem_next;
  logic [VW:0]    trial;

  always_comb begin
    q_next   = q;
    rem_next = rem;
    trial    = '0;
    for (int k = 0; k < 2; k++) begin
      trial  = {rem_next, q_next[DWP-1]};
      q_next = {q_next[DWP-2:0], 1'b0};
      if (trial >= {1'b0, d}) begin
        trial     = trial - {1'b0, d};
        q_next[0] = 1'b1;
      end
      rem_next = trial[VW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(STEPS);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= DWP'(dividend);
      rem <= '0;
      d   <= divisor;
    end else if (busy) begin
      q   <= q_next;
      rem <= rem_next;
    end
  end

  assign quotient  = q[DW-1:0];
  assign remainder = rem;

endmodule

### rtl/core/rsb_ctrl.sv
// ----------------------------------------------------------------------------
// rsb_ctrl
// Sequencer: accept, two divide passes, clamp, result handoff.
// ----------------------------------------------------------------------------
module rsb_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output rsb_pkg::cmd_t    cmd,
  input  rsb_pkg::status_t status
);

  rsb_pkg::state_t state;
  rsb_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rsb_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      rsb_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = rsb_pkg::ST_START1;
        end
      end
      rsb_pkg::ST_START1: begin
        cmd.start1 = 1'b1;
        state_next = rsb_pkg::ST_WAIT1;
      end
      rsb_pkg::ST_WAIT1: begin
        if (!status.div_busy) begin
          state_next = rsb_pkg::ST_CLAMP;
        end
      end
      rsb_pkg::ST_CLAMP: begin
        cmd.clamp  = 1'b1;
        state_next = rsb_pkg::ST_START2;
      end
      rsb_pkg::ST_START2: begin
        cmd.start2 = 1'b1;
        state_next = rsb_pkg::ST_WAIT2;
      end
      rsb_pkg::ST_WAIT2: begin
        if (!status.div_busy) begin
          state_next = rsb_pkg::ST_FINISH;
        end
      end
      rsb_pkg::ST_FINISH: begin
        // wait for the output word to be free
        if (!out_valid || out_ready) begin
          cmd.finish = 1'b1;
          state_next = rsb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = rsb_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/core/rsb_dp.sv
// ----------------------------------------------------------------------------
// rsb_dp
// Datapath: fill error, band test, estimate clamp, ratio smoothing.
// ----------------------------------------------------------------------------
module rsb_dp #(
  parameter int RATIO_FRAC_BITS = 20,
  parameter int FILL_BITS       = 20
) (
  input  logic                                clk,
  input  logic                                rst,
  input  rsb_pkg::cmd_t                       cmd,
  output rsb_pkg::status_t                    status,
  input  logic [FILL_BITS-1:0]                fill_level,
  input  logic [RATIO_FRAC_BITS+3:0]          nominal,
  input  logic [FILL_BITS-1:0]                capacity,
  input  logic [rsb_pkg::BLK_W-1:0]           blk,
  input  logic                                nom_load,
  input  logic [RATIO_FRAC_BITS+3:0]          nom_wdata,
  output logic [RATIO_FRAC_BITS+3:0]          ratio,
  output logic                                in_band,
  output logic                                clamped
);

  localparam int F      = RATIO_FRAC_BITS;
  localparam int RB     = F + 4;
  localparam int MW     = FILL_BITS + 1;
  localparam int DLT_W  = MW + F;
  localparam int FIN_W  = RB + 11;
  localparam int DWA    = (DLT_W > FIN_W) ? DLT_W : FIN_W;
  localparam int EW     = RB + 1;
  localparam int VW     = rsb_pkg::DIVISOR_W;
  localparam int BW     = FILL_BITS + 7;
  localparam logic [RB-1:0] NOM_RST = RB'(1) << F;

  logic [FILL_BITS-1:0] fill_q;
  logic [RB-1:0]        cur;
  logic [EW-1:0]        est;
  logic                 clamp_q;

  // fill error against half capacity
  logic [MW-1:0]  twice_fill;
  logic [MW-1:0]  cap_x;
  logic           above;
  logic [MW-1:0]  mag;
  logic [rsb_pkg::BLK_W-1:0] blk_eff;
  logic [VW-1:0]  blk2;

  assign twice_fill = {fill_q, 1'b0};
  assign cap_x      = {1'b0, capacity};
  assign above      = cap_x >= twice_fill;
  assign mag        = above ? (cap_x - twice_fill) : (twice_fill - cap_x);
  assign blk_eff    = (blk == '0) ? rsb_pkg::BLK_W'(1) : blk;
  assign blk2       = {blk_eff, 1'b0};

  // exact 49..51 percent band test
  logic [BW-1:0] fill_pct;
  logic [BW-1:0] cap_lo;
  logic [BW-1:0] cap_hi;
  logic          band;

  assign fill_pct = BW'(fill_q) * BW'(rsb_pkg::BAND_SCALE);
  assign cap_lo   = BW'(capacity) * BW'(rsb_pkg::BAND_LO);
  assign cap_hi   = BW'(capacity) * BW'(rsb_pkg::BAND_HI);
  assign band     = !((fill_pct < cap_lo) || (fill_pct > cap_hi));

  // dividers
  logic [DWA-1:0] a_dividend;
  logic [VW-1:0]  a_divisor;
  logic           a_busy;
  logic [DWA-1:0] a_quo;
  logic [VW-1:0]  a_rem;
  logic           b_busy;
  logic [RB-1:0]  b_quo;
  logic [rsb_pkg::NOM_DIV_W-1:0] b_rem;

  logic [RB+9:0]  slow_prod;
  logic [RB+4:0]  fast_prod;
  logic [DWA-1:0] fin_dividend;

  assign slow_prod    = (RB+10)'(cur) * (RB+10)'(rsb_pkg::SLOW_KEEP);
  assign fast_prod    = (RB+5)'(cur) * (RB+5)'(rsb_pkg::FAST_KEEP);
  assign fin_dividend = band ? (DWA'(fast_prod) + DWA'(nominal))
                             : (DWA'(slow_prod) + DWA'(est));

  always_comb begin
    if (cmd.start2) begin
      a_dividend = fin_dividend;
      a_divisor  = band ? VW'(rsb_pkg::TEN) : VW'(rsb_pkg::THOUSAND);
    end else begin
      a_dividend = DWA'({mag, {F{1'b0}}});
      a_divisor  = blk2;
    end
  end

  rsb_div #(
    .DW(DWA),
    .VW(VW)
  ) u_div_main (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.start1 | cmd.start2),
    .dividend  (a_dividend),
    .divisor   (a_divisor),
    .busy      (a_busy),
    .quotient  (a_quo),
    .remainder (a_rem)
  );

  rsb_div #(
    .DW(RB),
    .VW(rsb_pkg::NOM_DIV_W)
  ) u_div_nom (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.start1),
    .dividend  (nominal),
    .divisor   (rsb_pkg::NOM_DIV_W'(rsb_pkg::TEN)),
    .busy      (b_busy),
    .quotient  (b_quo),
    .remainder (b_rem)
  );

  assign status.div_busy = a_busy | b_busy;

  // hi = nom + floor(nom/10), lo = nom - ceil(nom/10)
  logic           rem_nz;
  logic [DWA-1:0] up_room;
  logic [DWA-1:0] dn_room;
  logic [EW-1:0]  hi;
  logic [EW-1:0]  lo;
  logic [EW-1:0]  est_next;
  logic           clamp_next;

  assign rem_nz  = b_rem != '0;
  assign up_room = DWA'(b_quo);
  assign dn_room = DWA'(b_quo) + DWA'(rem_nz);
  assign hi      = EW'(nominal) + EW'(b_quo);
  assign lo      = EW'(nominal) - EW'(b_quo) - EW'(rem_nz);

  always_comb begin
    clamp_next = 1'b0;
    if (above) begin
      if (a_quo > up_room) begin
        est_next   = hi;
        clamp_next = 1'b1;
      end else begin
        est_next = EW'(nominal) + EW'(a_quo[RB-1:0]);
      end
    end else begin
      if (a_quo > dn_room) begin
        est_next   = lo;
        clamp_next = 1'b1;
      end else begin
        est_next = EW'(nominal) - EW'(a_quo[RB-1:0]);
      end
    end
  end

  logic [RB-1:0] next_ratio;

  assign next_ratio = (a_quo[DWA-1:RB] != '0) ? {RB{1'b1}} : a_quo[RB-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= NOM_RST;
    end else if (nom_load) begin
      cur <= nom_wdata;
    end else if (cmd.finish) begin
      cur <= next_ratio;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      fill_q <= fill_level;
    end
    if (cmd.clamp) begin
      est     <= est_next;
      clamp_q <= clamp_next;
    end
    if (cmd.finish) begin
      ratio   <= next_ratio;
      in_band <= band;
      clamped <= clamp_q;
    end
  end

endmodule

### tb/resample_ratio_buffer_servo_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// resample_ratio_buffer_servo_tb
// Self-checking bench for the buffer-fill ratio servo. Fill words go in with
// random gaps; a ledger class tracks the servo ratio and register state and
// checks every result word. Registers are rewritten between phases while the
// block is idle, covering reset values, zero and extreme settings and
// randomized ones.
// ----------------------------------------------------------------------------
module resample_ratio_buffer_servo_tb;
  import rsb_pkg::*;

  localparam int FRAC           = 20;
  localparam int FILL_W         = 20;
  localparam int RATIO_W        = FRAC + 4;
  localparam int FILL_MAX       = (1 << FILL_W) - 1;
  localparam logic [RATIO_W-1:0] RATIO_MAX = '1;
  localparam logic [1:0] REG_SPARE = 2'd3;    // no register behind this index
  localparam int RANDOM_PHASES  = 12;
  localparam int PHASE_FILLS    = 153;
  localparam int PRESSURE_PHASE = 2;
  localparam int HOLD_CYCLES    = 700;
  localparam int DRAIN_CYCLES   = 64;
  localparam int CYCLE_LIMIT    = 1_000_000;
  localparam int MAX_SHOWN      = 100;

  typedef struct {
    logic [RATIO_W-1:0] ratio;
    logic               in_band;
    logic               clamped;
  } ratio_word_t;

  class ratio_ledger;
    longint unsigned nominal, capacity, blk_len, cur_ratio;
    ratio_word_t     expected_q[$];
    int              errors;

    function new();
      nominal   = 64'd1 << FRAC;
      capacity  = CAP_RST;
      blk_len   = BLK_RST;
      cur_ratio = nominal;
      errors    = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_NOMINAL: begin
          nominal   = value[RATIO_W-1:0];
          cur_ratio = nominal;
        end
        REG_CAPACITY: capacity = value[FILL_W-1:0];
        REG_BLOCK:    blk_len  = value[BLK_W-1:0];
        default: ;
      endcase
    endfunction

    function void accept_fill(logic [FILL_W-1:0] fill);
      longint unsigned blk, hi, lo, fill64, twice, mag, delta, est, nxt;
      bit              above;
      ratio_word_t     w;
      blk    = (blk_len == 0) ? 64'd1 : blk_len;
      hi     = nominal * 11 / TEN;
      lo     = nominal * 9 / TEN;
      fill64 = fill;
      twice  = fill64 * 2;
      above  = capacity >= twice;
      mag    = above ? capacity - twice : twice - capacity;
      delta  = (mag << FRAC) / (blk * 2);
      w.clamped = 1'b0;
      if (above) begin
        if (delta > hi - nominal) begin
          est       = hi;
          w.clamped = 1'b1;
        end else begin
          est = nominal + delta;
        end
      end else begin
        if (delta > nominal - lo) begin
          est       = lo;
          w.clamped = 1'b1;
        end else begin
          est = nominal - delta;
        end
      end
      w.in_band = !(fill64 * BAND_SCALE < capacity * BAND_LO ||
                    fill64 * BAND_SCALE > capacity * BAND_HI);
      if (w.in_band) nxt = (cur_ratio * FAST_KEEP + nominal) / TEN;
      else nxt = (cur_ratio * SLOW_KEEP + est) / THOUSAND;
      if (nxt > RATIO_MAX) nxt = RATIO_MAX;
      cur_ratio = nxt;
      w.ratio   = nxt[RATIO_W-1:0];
      expected_q.push_back(w);
    endfunction

    function void flag(string what, longint unsigned exp_v, longint unsigned got_v);
      errors++;
      if (errors <= MAX_SHOWN)
        $display("%0t: %s expected %0h actual %0h", $time, what, exp_v, got_v);
    endfunction

    function void check_word(logic [RATIO_W-1:0] ratio, logic in_band, logic clamped);
      ratio_word_t w;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= MAX_SHOWN)
          $display("%0t: ratio word expected none actual %0h", $time, ratio);
        return;
      end
      w = expected_q.pop_front();
      if (ratio !== w.ratio) flag("ratio", w.ratio, ratio);
      if (in_band !== w.in_band) flag("in_band", w.in_band, in_band);
      if (clamped !== w.clamped) flag("clamped", w.clamped, clamped);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;

  rsb_fill_if  #(.FILL_BITS(FILL_W))   fill_ch ();
  rsb_ratio_if #(.RATIO_BITS(RATIO_W)) ratio_ch ();

  resample_ratio_buffer_servo #(
    .RATIO_FRAC_BITS(FRAC),
    .FILL_BITS      (FILL_W)
  ) uut (
    .clk    (clk),
    .rst    (rst),
    .fill   (fill_ch),
    .result (ratio_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  ratio_ledger ledger;
  bit          tx_idle;
  bit          rx_idle;
  bit          hold_off;
  int          phase_no;
  int          cycle_count = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("resample_ratio_buffer_servo_tb: done, errors");
      $finish;
    end
  end

  // result side: random stall after each word while rx_idle is set, plus the long hold-off
  initial begin
    int stall;
    stall = 0;
    ratio_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst) begin
        if (ratio_ch.valid && ratio_ch.ready) begin
          ledger.check_word(ratio_ch.ratio, ratio_ch.in_band, ratio_ch.clamped);
          stall = rx_idle ? $urandom_range(0, 16) : 0;
        end else if (stall > 0) begin
          stall--;
        end
        ratio_ch.ready <= !hold_off && stall == 0;
      end
    end
  end

  // blocks the result side long enough for the servo to back up its input
  initial begin
    hold_off = 1'b0;
    wait (phase_no == PRESSURE_PHASE);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    ledger.set_reg(idx, value);
  endtask

  task automatic send_fill(logic [FILL_W-1:0] f);
    int gap;
    gap = tx_idle ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      fill_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    fill_ch.valid      <= 1'b1;
    fill_ch.fill_level <= f;
    do @(posedge clk); while (!fill_ch.ready);
    ledger.accept_fill(f);
  endtask

  // drop valid and wait for every outstanding word before touching registers
  task automatic settle();
    fill_ch.valid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int          center, offset, span, f_int;
    logic [31:0] nom_v, cap_v, blk_v;

    ledger             = new();
    rst                = 1'b1;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    fill_ch.valid      = 1'b0;
    fill_ch.fill_level = '0;
    tx_idle            = 1'b1;
    rx_idle            = 1'b1;
    phase_no           = -1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset values: extremes, midpoint, band edges, clamp boundary
    send_fill(20'd0);
    send_fill(FILL_MAX);
    send_fill(20'd44100);
    send_fill(20'd43217);
    send_fill(20'd43218);
    send_fill(20'd44982);
    send_fill(20'd44983);
    send_fill(20'd44056);
    send_fill(20'd44055);

    // zero capacity and zero block length, with junk above the field widths
    settle();
    write_reg(REG_CAPACITY, 32'hFFF0_0000);
    write_reg(REG_BLOCK, 32'hABCD_0000);
    send_fill(20'd0);
    send_fill(20'd1);
    send_fill(FILL_MAX);

    // full-scale nominal: estimate above range saturates the ratio
    settle();
    write_reg(REG_NOMINAL, 32'h5AFF_FFFF);
    write_reg(REG_CAPACITY, 32'h000F_FFFF);
    write_reg(REG_BLOCK, 32'h0000_0001);
    send_fill(20'd0);
    send_fill(20'd524287);
    send_fill(20'd524288);
    send_fill(FILL_MAX);

    // zero nominal, spare register index, smallest capacity, largest block
    settle();
    write_reg(REG_NOMINAL, 32'hC300_0000);
    write_reg(REG_SPARE, $urandom);
    write_reg(REG_CAPACITY, 32'h0000_0001);
    write_reg(REG_BLOCK, 32'h0000_FFFF);
    send_fill(20'd0);
    send_fill(20'd1);
    send_fill(FILL_MAX);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      case ($urandom_range(0, 3))
        0:       nom_v = 32'h0010_0000 + $urandom_range(0, 'h2000) - 'h1000;
        1:       nom_v = $urandom;
        2:       nom_v = $urandom_range('h0C_0000, 'h14_0000);
        default: nom_v = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      endcase
      case ($urandom_range(0, 3))
        0:       cap_v = $urandom_range(1, 200);
        1:       cap_v = $urandom_range(1, FILL_MAX);
        2:       cap_v = $urandom_range(80000, 100000);
        default: cap_v = $urandom_range(0, 1) ? FILL_MAX : 1;
      endcase
      case ($urandom_range(0, 3))
        0:       blk_v = $urandom_range(1, 1000);
        1:       blk_v = $urandom_range(1, 65535);
        2:       blk_v = $urandom_range(200, 600);
        default: blk_v = $urandom_range(0, 2) == 0 ? 0 : ($urandom_range(0, 1) ? 65535 : 1);
      endcase
      write_reg(REG_NOMINAL, nom_v);
      write_reg(REG_CAPACITY, cap_v);
      write_reg(REG_BLOCK, blk_v);

      tx_idle = (p % 4 != 3);
      rx_idle <= (p % 4 != 3) && (p % 3 != 1);
      phase_no <= p;

      for (int i = 0; i < PHASE_FILLS; i++) begin
        center = int'(ledger.capacity / 2);
        case ($urandom_range(0, 3))
          0:       f_int = $urandom_range(0, FILL_MAX);
          3:       f_int = $urandom_range(0, int'(ledger.capacity));
          default: begin
            // near half full: inside/around the band, or close enough to stay unclamped
            span   = ($urandom_range(0, 1) == 1) ? int'(ledger.capacity / 50) + 2
                                                 : int'(ledger.blk_len / 8) + 1;
            offset = $urandom_range(0, span);
            if ($urandom_range(0, 1) == 1) offset = -offset;
            f_int  = center + offset;
          end
        endcase
        if (f_int < 0) f_int = 0;
        if (f_int > FILL_MAX) f_int = FILL_MAX;
        send_fill(f_int[FILL_W-1:0]);
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (ledger.errors == 0 && ledger.pending() == 0) begin
      $display("resample_ratio_buffer_servo_tb: done, clean");
    end else begin
      $display("resample_ratio_buffer_servo_tb: done, errors");
    end
    $finish;
  end

endmodule
